/* src/gsa_pkg.sv */
`default_nettype none

package gsa_pkg;

  localparam int OP_W        = 2;
  localparam int IDX_PORT_W  = 10;
  localparam int GEN_PORT_W  = 32;
  localparam int FREE_PORT_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2
  } gsa_op_t;

  // control from the processing stage to the free stack
  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } gsa_stk_ctl_t;

  // control to the generation table
  typedef struct packed {
    logic clr;
    logic we;
    logic re;
  } gsa_gen_ctl_t;

endpackage

`default_nettype wire

/* src/gsa_free_stack.sv */
`default_nettype none

module gsa_slot_stack import gsa_pkg::*; #(
  parameter int SLOTS = 1024,
  parameter int IDX_W = $clog2(SLOTS),
  parameter int DEP_W = $clog2(SLOTS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire gsa_stk_ctl_t       ctl,
  input  wire logic [IDX_W-1:0]   clr_addr,
  input  wire logic [IDX_W-1:0]   push_slot,
  output logic      [DEP_W-1:0]   depth,
  output logic      [DEP_W-1:0]   depth_nxt,
  output logic      [IDX_W-1:0]   top,
  output logic      [IDX_W-1:0]   top_nxt
);

  logic [IDX_W-1:0] stack_mem [SLOTS];
  logic [DEP_W-1:0] depth_r;
  logic [IDX_W-1:0] top_r;
  // prefetched entry just below the top
  logic [IDX_W-1:0] below_r;
  logic [DEP_W-1:0] rd_addr;

  always_comb begin
    depth_nxt = depth_r;
    top_nxt   = top_r;
    if (ctl.clr) begin
      depth_nxt = DEP_W'(SLOTS);
      top_nxt   = '0;
    end else if (ctl.push) begin
      depth_nxt = depth_r + DEP_W'(1);
      top_nxt   = push_slot;
    end else if (ctl.pop) begin
      depth_nxt = depth_r - DEP_W'(1);
      top_nxt   = below_r;
    end
  end

  // never collides with the push address written in the same cycle
  assign rd_addr = depth_nxt - DEP_W'(2);

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      stack_mem[clr_addr] <= IDX_W'(SLOTS - 1) - clr_addr;
    end else if (ctl.push) begin
      stack_mem[depth_r[IDX_W-1:0]] <= push_slot;
    end
    below_r <= stack_mem[rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DEP_W'(SLOTS);
      top_r   <= '0;
    end else begin
      depth_r <= depth_nxt;
      top_r   <= top_nxt;
    end
  end

  assign depth = depth_r;
  assign top   = top_r;

endmodule

`default_nettype wire

/* src/gsa_gen_table.sv */
`default_nettype none

module gsa_gen_table import gsa_pkg::*; #(
  parameter int SLOTS    = 1024,
  parameter int GEN_BITS = 32,
  parameter int IDX_W    = $clog2(SLOTS)
) (
  input  wire logic                clk,
  input  wire gsa_gen_ctl_t        ctl,
  input  wire logic [IDX_W-1:0]    clr_addr,
  input  wire logic [IDX_W-1:0]    waddr,
  input  wire logic [GEN_BITS-1:0] wdata,
  input  wire logic [IDX_W-1:0]    raddr,
  output logic      [GEN_BITS-1:0] rdata
);

  logic [GEN_BITS-1:0] gen_mem [SLOTS];
  logic [GEN_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      gen_mem[clr_addr] <= '0;
    end else if (ctl.we) begin
      gen_mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      // bypass the update landing at the same edge
      if (ctl.we && waddr == raddr) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= gen_mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/generational_slot_allocator.sv */
`default_nettype none

// Generational slot allocator: SLOTS slots handed out from a LIFO free stack,
// each with a GEN_BITS generation counter. op 0 allocates, op 1 frees a handle,
// op 2 checks a handle for liveness; every word in gives exactly one word out.
// Sustained rate is one word per cycle while out_stall does not hold the
// result; an accepted word goes into the input register and on into the result
// register once that is free or being taken (input register, then result
// register). The stack top sits in a register with the entry below it prefetched
// from the stack memory, and the generation table's single registered read port
// is addressed at acceptance, bypassing the update retiring in the same cycle.
// After reset a clearing pass loads both memories; in_stall is high during it.
module generational_slot_allocator import gsa_pkg::*; #(
  parameter int SLOTS    = 1024,
  parameter int GEN_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [OP_W-1:0]        in_op,
  input  wire logic [IDX_PORT_W-1:0]  in_slot_index,
  input  wire logic [GEN_PORT_W-1:0]  in_handle_generation,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_ok,
  output logic [IDX_PORT_W-1:0]       out_granted_slot,
  output logic [GEN_PORT_W-1:0]       out_granted_generation,
  output logic [FREE_PORT_W-1:0]      out_free_slots
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int DEP_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (GEN_BITS > GEN_PORT_W) ? GEN_BITS : GEN_PORT_W;

  logic                   clearing_r;
  logic [IDX_W-1:0]       clr_cnt_r;

  logic                   proc_valid_r;
  logic [OP_W-1:0]        proc_op_r;
  logic [IDX_PORT_W-1:0]  proc_idx_r;
  logic [GEN_PORT_W-1:0]  proc_gen_r;

  logic                   out_valid_r;
  logic                   out_ok_r;
  logic [IDX_PORT_W-1:0]  out_slot_r;
  logic [GEN_PORT_W-1:0]  out_gen_r;
  logic [FREE_PORT_W-1:0] out_free_r;

  logic                   accept;
  logic                   fire;
  logic                   handle_ok;
  logic                   res_ok;
  logic [IDX_W-1:0]       res_slot;
  logic [GEN_BITS-1:0]    res_gen;

  gsa_stk_ctl_t           stk_ctl;
  gsa_gen_ctl_t           gen_ctl;
  logic [DEP_W-1:0]       depth;
  logic [DEP_W-1:0]       depth_nxt;
  logic [IDX_W-1:0]       top;
  logic [IDX_W-1:0]       top_nxt;
  logic [IDX_W-1:0]       gen_waddr;
  logic [IDX_W-1:0]       gen_raddr;
  logic [GEN_BITS-1:0]    gen_rd;
  logic [GEN_BITS-1:0]    gen_inc;

  gsa_slot_stack #(.SLOTS(SLOTS), .IDX_W(IDX_W), .DEP_W(DEP_W)) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (stk_ctl),
    .clr_addr  (clr_cnt_r),
    .push_slot (IDX_W'(proc_idx_r)),
    .depth     (depth),
    .depth_nxt (depth_nxt),
    .top       (top),
    .top_nxt   (top_nxt)
  );

  gsa_gen_table #(.SLOTS(SLOTS), .GEN_BITS(GEN_BITS), .IDX_W(IDX_W)) u_gen (
    .clk      (clk),
    .ctl      (gen_ctl),
    .clr_addr (clr_cnt_r),
    .waddr    (gen_waddr),
    .wdata    (gen_inc),
    .raddr    (gen_raddr),
    .rdata    (gen_rd)
  );

  assign fire     = proc_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (proc_valid_r && !fire);
  assign accept   = in_valid && !in_stall;

  // allocate reads the generation of whatever will be on top next cycle
  assign gen_raddr = (in_op == OP_ALLOC) ? top_nxt : IDX_W'(in_slot_index);
  assign gen_inc   = gen_rd + GEN_BITS'(1);

  assign handle_ok = (proc_gen_r != '0) && (32'(proc_idx_r) < SLOTS) &&
                     (CMP_W'(gen_rd) == CMP_W'(proc_gen_r));

  always_comb begin
    res_ok       = 1'b0;
    res_slot     = '0;
    res_gen      = '0;
    stk_ctl.clr  = clearing_r;
    stk_ctl.push = 1'b0;
    stk_ctl.pop  = 1'b0;
    gen_ctl.clr  = clearing_r;
    gen_ctl.we   = 1'b0;
    gen_ctl.re   = accept;
    gen_waddr    = top;
    case (proc_op_r)
      OP_ALLOC: begin
        if (depth != '0) begin
          res_ok      = 1'b1;
          res_slot    = top;
          res_gen     = gen_inc;
          stk_ctl.pop = fire;
          gen_ctl.we  = fire;
        end
      end
      OP_FREE: begin
        if (handle_ok && depth != DEP_W'(SLOTS)) begin
          res_ok       = 1'b1;
          stk_ctl.push = fire;
          gen_ctl.we   = fire;
          gen_waddr    = IDX_W'(proc_idx_r);
        end
      end
      OP_QUERY: begin
        res_ok = handle_ok;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      if (clr_cnt_r == IDX_W'(SLOTS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        proc_valid_r <= 1'b1;
      end else if (fire) begin
        proc_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      proc_op_r  <= in_op;
      proc_idx_r <= in_slot_index;
      proc_gen_r <= in_handle_generation;
    end
    if (fire) begin
      out_ok_r   <= res_ok;
      out_slot_r <= IDX_PORT_W'(res_slot);
      out_gen_r  <= GEN_PORT_W'(res_gen);
      out_free_r <= FREE_PORT_W'(depth_nxt);
    end
  end

  assign out_valid              = out_valid_r;
  assign out_ok                 = out_ok_r;
  assign out_granted_slot       = out_slot_r;
  assign out_granted_generation = out_gen_r;
  assign out_free_slots         = out_free_r;

endmodule

`default_nettype wire

/* src/gsa_checker.sv */
`default_nettype none

module gsa_checker import gsa_pkg::*; #(
  parameter int SLOTS = 1024
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic                   out_ok,
  input wire logic [IDX_PORT_W-1:0]  out_granted_slot,
  input wire logic [GEN_PORT_W-1:0]  out_granted_generation,
  input wire logic [FREE_PORT_W-1:0] out_free_slots
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok) &&
      $stable(out_granted_slot) && $stable(out_granted_generation) &&
      $stable(out_free_slots))
    else $error("result word changed while stalled");

  // the memories are being loaded right after reset
  a_clear_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

  // a failed operation grants nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_granted_slot == '0 && out_granted_generation == '0)
    else $error("failed operation reports a grant");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_free_slots) <= SLOTS)
    else $error("free count beyond pool size");

endmodule

bind generational_slot_allocator gsa_checker #(.SLOTS(SLOTS)) u_gsa_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_ok                 (out_ok),
  .out_granted_slot       (out_granted_slot),
  .out_granted_generation (out_granted_generation),
  .out_free_slots         (out_free_slots)
);

`default_nettype wire

/* tb/sv/tb_generational_slot_allocator.sv */
`timescale 1ns / 100ps

module tb_generational_slot_allocator;
  import gsa_pkg::*;

  localparam int SLOT_COUNT  = 1024;
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 8000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic                   ok;
    logic [IDX_PORT_W-1:0]  slot;
    logic [GEN_PORT_W-1:0]  gen;
    logic [FREE_PORT_W-1:0] free;
  } outcome_t;

  typedef struct packed {
    logic [IDX_PORT_W-1:0] slot;
    logic [GEN_PORT_W-1:0] gen;
  } handle_t;

  typedef enum {MIX_PHASE, DRAIN_PHASE, REFILL_PHASE} phase_t;
  typedef enum {FLOW, LIGHT, HEAVY, CHOPPY} stall_mode_t;

  class slot_pool_scoreboard;
    logic [GEN_PORT_W-1:0] slot_gen [SLOT_COUNT];
    logic [IDX_PORT_W-1:0] spare_slots [SLOT_COUNT];
    int unsigned depth;
    outcome_t outcome_q[$];
    handle_t live[$];
    int errors, allocs, empty_allocs, frees, rejects, lives;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        spare_slots[i] = IDX_PORT_W'(SLOT_COUNT - 1 - i);
        slot_gen[i] = '0;
      end
      depth = SLOT_COUNT;
    endfunction

    // generation zero is the null handle; a free slot's handle still matches
    function bit handle_live(logic [IDX_PORT_W-1:0] idx, logic [GEN_PORT_W-1:0] gen);
      return gen != '0 && int'(idx) < SLOT_COUNT && slot_gen[idx] == gen;
    endfunction

    function void note_word(logic [OP_W-1:0] op, logic [IDX_PORT_W-1:0] idx,
                            logic [GEN_PORT_W-1:0] gen);
      outcome_t e;
      logic [IDX_PORT_W-1:0] s;
      e = '0;
      case (op)
        OP_ALLOC: begin
          if (depth > 0) begin
            depth--;
            s = spare_slots[depth];
            slot_gen[s] = slot_gen[s] + 1'b1;
            e.ok = 1'b1;
            e.slot = s;
            e.gen = slot_gen[s];
            live.push_back(handle_t'{slot: s, gen: slot_gen[s]});
            allocs++;
          end else begin
            empty_allocs++;
          end
        end
        OP_FREE: begin
          if (handle_live(idx, gen) && depth < SLOT_COUNT) begin
            spare_slots[depth] = idx;
            depth++;
            slot_gen[idx] = slot_gen[idx] + 1'b1;
            e.ok = 1'b1;
            frees++;
          end else begin
            rejects++;
          end
        end
        OP_QUERY: begin
          e.ok = handle_live(idx, gen);
          if (e.ok) lives++;
        end
        default: ;
      endcase
      e.free = FREE_PORT_W'(depth);
      outcome_q.push_back(e);
    endfunction

    function void check_word(logic ok, logic [IDX_PORT_W-1:0] slot,
                             logic [GEN_PORT_W-1:0] gen, logic [FREE_PORT_W-1:0] free);
      outcome_t e;
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result word ok=%0b slot=%0d gen=%0h free=%0d",
                 $time, ok, slot, gen, free);
        errors++;
        return;
      end
      e = outcome_q.pop_front();
      if (ok !== e.ok) begin
        $display("%0t: ok expected %0b actual %0b", $time, e.ok, ok);
        errors++;
      end
      if (slot !== e.slot) begin
        $display("%0t: granted_slot expected %0d actual %0d", $time, e.slot, slot);
        errors++;
      end
      if (gen !== e.gen) begin
        $display("%0t: granted_generation expected %0h actual %0h", $time, e.gen, gen);
        errors++;
      end
      if (free !== e.free) begin
        $display("%0t: free_slots expected %0d actual %0d", $time, e.free, free);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [OP_W-1:0]        in_op;
  logic [IDX_PORT_W-1:0]  in_slot_index;
  logic [GEN_PORT_W-1:0]  in_handle_generation;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_ok;
  logic [IDX_PORT_W-1:0]  out_granted_slot;
  logic [GEN_PORT_W-1:0]  out_granted_generation;
  logic [FREE_PORT_W-1:0] out_free_slots;

  slot_pool_scoreboard sb;
  bit hold_req;
  int burst_left;
  int stuck;

  generational_slot_allocator #(
    .SLOTS    (SLOT_COUNT),
    .GEN_BITS (32)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_op                  (in_op),
    .in_slot_index          (in_slot_index),
    .in_handle_generation   (in_handle_generation),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_ok                 (out_ok),
    .out_granted_slot       (out_granted_slot),
    .out_granted_generation (out_granted_generation),
    .out_free_slots         (out_free_slots)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_PORT_W-1:0] idx,
                           input logic [GEN_PORT_W-1:0] gen);
    in_valid <= 1'b1;
    in_op <= op;
    in_slot_index <= idx;
    in_handle_generation <= gen;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(op, idx, gen);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outcome_q.size() != 0);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 30);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // mostly handles that were handed out, some of them made stale
  function automatic handle_t pick_handle(bit take);
    handle_t h;
    int k;
    if (sb.live.size() == 0)
      return handle_t'{slot: IDX_PORT_W'($urandom), gen: GEN_PORT_W'($urandom_range(1, 4))};
    k = $urandom_range(0, sb.live.size() - 1);
    h = sb.live[k];
    if (take) sb.live.delete(k);
    case ($urandom_range(0, 14))
      0: h.gen = h.gen + 1'b1;
      1: h.gen = h.gen - 1'b1;
      2: h.gen = h.gen ^ (32'h1 << $urandom_range(0, 31));
      default: ;
    endcase
    return h;
  endfunction

  task automatic run_phase(input phase_t ph, input int count, input bit paced);
    logic [OP_W-1:0] op;
    logic [IDX_PORT_W-1:0] idx;
    logic [GEN_PORT_W-1:0] gen;
    handle_t h;
    int r, w_alloc, w_free, w_query;
    case (ph)
      MIX_PHASE: begin
        w_alloc = 35; w_free = 65; w_query = 85;
      end
      DRAIN_PHASE: begin
        w_alloc = 88; w_free = 94; w_query = 97;
      end
      default: begin
        w_alloc = 20; w_free = 70; w_query = 85;
      end
    endcase
    repeat (count) begin
      r = $urandom_range(0, 99);
      op = OP_W'($urandom_range(0, 3));
      idx = IDX_PORT_W'($urandom);
      gen = $urandom_range(0, 1) ? GEN_PORT_W'($urandom) : GEN_PORT_W'($urandom_range(0, 4));
      if (r < w_alloc) begin
        op = OP_ALLOC;
      end else if (r < w_query) begin
        op = (r < w_free) ? OP_FREE : OP_QUERY;
        h = pick_handle(r < w_free);
        idx = h.slot;
        gen = h.gen;
      end
      send_word(op, idx, gen);
      if (paced) pace();
    end
  endtask

  initial begin
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_ALLOC;
    in_slot_index <= '0;
    in_handle_generation <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_word(OP_QUERY, 10'd0, 32'd0);
    send_word(OP_ALLOC, 10'd0, 32'd0);
    send_word(OP_QUERY, 10'd0, 32'd1);
    send_word(OP_FREE, 10'd0, 32'd0);
    send_word(OP_FREE, 10'd0, 32'd2);
    send_word(OP_FREE, 10'd0, 32'd1);
    send_word(OP_FREE, 10'd0, 32'd2);       // passes the checks, stack already full
    send_word(OP_QUERY, 10'd0, 32'd2);      // slot on the free stack still matches
    send_word(OP_ALLOC, 10'd0, 32'd0);
    send_word(OP_ALLOC, 10'h3ff, 32'hffff_ffff);
    send_word(OP_FREE, 10'd1, 32'd1);
    send_word(OP_FREE, 10'd1, 32'd2);       // pushes a free slot a second time
    send_word(OP_QUERY, 10'd1, 32'd3);
    send_word(OP_UNUSED, 10'h3ff, 32'hffff_ffff);
    send_word(OP_UNUSED, 10'd0, 32'd0);
    send_word(OP_QUERY, 10'h3ff, 32'hffff_ffff);
    send_word(OP_FREE, 10'h3ff, 32'hffff_ffff);
    send_word(OP_QUERY, 10'h2aa, 32'haaaa_aaaa);
    send_word(OP_QUERY, 10'h155, 32'h5555_5555);
    send_word(OP_ALLOC, 10'd0, 32'd0);
    send_word(OP_FREE, 10'd1, 32'd4);
    wait_drained();

    // receiver holds off while words keep coming
    hold_req = 1'b1;
    run_phase(MIX_PHASE, 60, 1'b0);
    run_phase(MIX_PHASE, 140, 1'b1);
    wait_drained();
    run_phase(DRAIN_PHASE, 1250, 1'b1);
    wait_drained();
    run_phase(REFILL_PHASE, 450, 1'b1);
    wait_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d allocations, %0d on an empty stack, %0d frees accepted, %0d rejected",
             sb.allocs, sb.empty_allocs, sb.frees, sb.rejects);
    $display("%0d queries found live handles; %0d result words still pending",
             sb.lives, sb.outcome_q.size());
    if (sb.errors == 0 && sb.outcome_q.size() == 0)
      $display("generational_slot_allocator: match");
    else
      $display("generational_slot_allocator: mismatch");
    $finish;
  end

  initial begin
    stall_mode_t mode;
    int span, hold_cnt;
    bit held;
    out_stall <= 1'b0;
    mode = FLOW;
    span = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        out_stall <= 1'b1;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
        held = 1'b1;
      end else begin
        if (span == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          span = $urandom_range(16, 96);
        end
        span--;
        case (mode)
          FLOW:    out_stall <= 1'b0;
          LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
          HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (span % 4 < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_word(out_ok, out_granted_slot, out_granted_generation, out_free_slots);
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, stuck);
        $display("generational_slot_allocator: mismatch");
        $finish;
      end
    end
  end

endmodule

/* generational_slot_allocator.f */
src/gsa_pkg.sv
src/gsa_free_stack.sv
src/gsa_gen_table.sv
src/generational_slot_allocator.sv
src/gsa_checker.sv
tb/sv/tb_generational_slot_allocator.sv
